// ===== rtl/mnpr_pkg.sv =====
// ----------------------------------------------------------------------------
// mnpr_pkg
// Shared constants and controller/datapath handshake types for the MIDI
// note pairing recorder.
// ----------------------------------------------------------------------------
package mnpr_pkg;

   localparam int CHANNEL_COUNT_DEFAULT = 16;
   localparam int TIME_BITS_DEFAULT     = 40;
   localparam int LATENCY_BITS          = 24;
   localparam int DATA_BITS             = 7;
   localparam int NOTES_PER_CHANNEL     = 128;

   // result kinds
   localparam logic [3:0] KIND_NONE      = 4'd0;
   localparam logic [3:0] KIND_NOTE      = 4'd1;
   localparam logic [3:0] KIND_KEYPRESS  = 4'd2;
   localparam logic [3:0] KIND_CTRL      = 4'd3;
   localparam logic [3:0] KIND_PROG      = 4'd4;
   localparam logic [3:0] KIND_CHANPRESS = 4'd5;
   localparam logic [3:0] KIND_BEND      = 4'd6;
   localparam logic [3:0] KIND_UNMATCHED = 4'd7;
   localparam logic [3:0] KIND_SYSTEM    = 4'd8;
   localparam logic [3:0] KIND_BAD       = 4'd9;

   // upper nibble of the status byte
   localparam logic [3:0] MSG_NOTE_OFF   = 4'h8;
   localparam logic [3:0] MSG_NOTE_ON    = 4'h9;
   localparam logic [3:0] MSG_KEYPRESS   = 4'hA;
   localparam logic [3:0] MSG_CTRL       = 4'hB;
   localparam logic [3:0] MSG_PROG       = 4'hC;
   localparam logic [3:0] MSG_CHANPRESS  = 4'hD;
   localparam logic [3:0] MSG_BEND       = 4'hE;

   typedef struct packed {
      logic capture;
      logic resolve;
      logic clear_step;
   } mnpr_cmd_type;

   typedef struct packed {
      logic clear_last;
   } mnpr_stat_type;

endpackage

// ===== rtl/mnpr_ctrl.sv =====
// ----------------------------------------------------------------------------
// mnpr_ctrl
// Sequencer: table clearing sweep after reset, then accept / resolve per
// message.
// ----------------------------------------------------------------------------
module mnpr_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   output mnpr_pkg::mnpr_cmd_type cmd,
   input  mnpr_pkg::mnpr_stat_type stat
);
   import mnpr_pkg::*;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_RESOLVE
   } state_type;

   state_type state_ff;
   logic      busy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         busy_ff  <= 1'b1;
      end else begin
         unique case (state_ff)
            ST_CLEAR: begin
               if (stat.clear_last) begin
                  state_ff <= ST_IDLE;
                  busy_ff  <= 1'b0;
               end
            end
            ST_IDLE: begin
               if (start) begin
                  state_ff <= ST_RESOLVE;
                  busy_ff  <= 1'b1;
               end
            end
            ST_RESOLVE: begin
               state_ff <= ST_IDLE;
               busy_ff  <= 1'b0;
            end
            default: begin
               state_ff <= ST_CLEAR;
               busy_ff  <= 1'b1;
            end
         endcase
      end
   end

   always_comb begin
      cmd.capture    = (state_ff == ST_IDLE) && start;
      cmd.resolve    = (state_ff == ST_RESOLVE);
      cmd.clear_step = (state_ff == ST_CLEAR);
   end

   assign busy = busy_ff;

endmodule

// ===== rtl/mnpr_datapath.sv =====
// ----------------------------------------------------------------------------
// mnpr_datapath
// Message registers, latency correction, open-note table and result
// registers.
// ----------------------------------------------------------------------------
module mnpr_datapath #(
   parameter int CHANNEL_COUNT = mnpr_pkg::CHANNEL_COUNT_DEFAULT,
   parameter int TIME_BITS     = mnpr_pkg::TIME_BITS_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  mnpr_pkg::mnpr_cmd_type                cmd,
   output mnpr_pkg::mnpr_stat_type               stat,
   input  logic                                  csr_we,
   input  logic [mnpr_pkg::LATENCY_BITS-1:0]     csr_wdata,
   input  logic [7:0]                            req_status_byte,
   input  logic [mnpr_pkg::DATA_BITS-1:0]        req_first_data,
   input  logic [mnpr_pkg::DATA_BITS-1:0]        req_second_data,
   input  logic [TIME_BITS-1:0]                  req_arrival_time_us,
   output logic                                  rsp_valid,
   output logic [3:0]                            rsp_kind,
   output logic [3:0]                            rsp_chan,
   output logic [mnpr_pkg::DATA_BITS-1:0]        rsp_out_first,
   output logic [mnpr_pkg::DATA_BITS-1:0]        rsp_out_second,
   output logic signed [TIME_BITS:0]             rsp_event_time_us,
   output logic [TIME_BITS-1:0]                  rsp_duration_us
);
   import mnpr_pkg::*;

   localparam int DEPTH      = CHANNEL_COUNT * NOTES_PER_CHANNEL;
   localparam int ADDR_BITS  = $clog2(DEPTH);
   localparam int ENTRY_BITS = 1 + DATA_BITS + TIME_BITS + 1;
   localparam int DIFF_BITS  = TIME_BITS + 2;

   // entry: {open, velocity, start time}
   logic [ENTRY_BITS-1:0] mem [0:DEPTH-1];

   logic [LATENCY_BITS-1:0]  latency_ff;
   logic [ADDR_BITS-1:0]     clr_cnt_ff;
   logic [7:0]               status_ff;
   logic [DATA_BITS-1:0]     first_ff;
   logic [DATA_BITS-1:0]     second_ff;
   logic signed [TIME_BITS:0] time_ff;
   logic                     tracked_ff;
   logic [ADDR_BITS-1:0]     addr_ff;
   logic [ENTRY_BITS-1:0]    rd_ff;

   logic                     rsp_valid_ff;
   logic [3:0]               kind_ff;
   logic [3:0]               chan_ff;
   logic [DATA_BITS-1:0]     out_first_ff;
   logic [DATA_BITS-1:0]     out_second_ff;
   logic signed [TIME_BITS:0] event_time_ff;
   logic [TIME_BITS-1:0]     duration_ff;

   logic [10:0]              addr_full;
   logic [ADDR_BITS-1:0]     raddr;
   logic signed [TIME_BITS:0] time_in;
   logic                     tracked_in;

   logic                     rd_open;
   logic [DATA_BITS-1:0]     rd_vel;
   logic signed [TIME_BITS:0] rd_time;
   logic signed [DIFF_BITS-1:0] diff;
   logic [TIME_BITS-1:0]     dur_clamped;
   logic [3:0]               msg_type;
   logic                     is_off;

   logic                     mem_we;
   logic [ADDR_BITS-1:0]     mem_waddr;
   logic [ENTRY_BITS-1:0]    mem_wdata;

   logic [3:0]               kind_in;
   logic [DATA_BITS-1:0]     out_second_in;
   logic signed [TIME_BITS:0] event_time_in;
   logic [TIME_BITS-1:0]     duration_in;

   // ------------------------------------------------------------ capture side
   assign addr_full  = {req_status_byte[3:0], req_first_data};
   assign raddr      = addr_full[ADDR_BITS-1:0];
   assign tracked_in = ({1'b0, req_status_byte[3:0]} < 5'(CHANNEL_COUNT));
   assign time_in    = $signed({1'b0, req_arrival_time_us})
                     - $signed({{(TIME_BITS+1-LATENCY_BITS){1'b0}}, latency_ff});

   always_ff @(posedge clock) begin
      if (reset) begin
         latency_ff <= '0;
         clr_cnt_ff <= '0;
      end else begin
         if (csr_we) begin
            latency_ff <= csr_wdata;
         end
         if (cmd.clear_step) begin
            clr_cnt_ff <= clr_cnt_ff + ADDR_BITS'(1);
         end
      end
   end

   assign stat.clear_last = (clr_cnt_ff == ADDR_BITS'(DEPTH - 1));

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         status_ff  <= req_status_byte;
         first_ff   <= req_first_data;
         second_ff  <= req_second_data;
         time_ff    <= time_in;
         tracked_ff <= tracked_in;
         addr_ff    <= raddr;
      end
   end

   // ------------------------------------------------------------ table
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (cmd.capture) begin
         rd_ff <= mem[raddr];
      end
   end

   // ------------------------------------------------------------ resolve side
   assign rd_open  = rd_ff[ENTRY_BITS-1];
   assign rd_vel   = rd_ff[ENTRY_BITS-2 -: DATA_BITS];
   assign rd_time  = $signed(rd_ff[TIME_BITS:0]);
   assign msg_type = status_ff[7:4];
   // note-on with velocity zero counts as note-off
   assign is_off   = (msg_type == MSG_NOTE_OFF)
                  || ((msg_type == MSG_NOTE_ON) && (second_ff == '0));

   assign diff = $signed({time_ff[TIME_BITS], time_ff})
               - $signed({rd_time[TIME_BITS], rd_time});

   always_comb begin
      if (diff[DIFF_BITS-1]) begin
         dur_clamped = '0;
      end else if (diff[TIME_BITS]) begin
         dur_clamped = '1;
      end else begin
         dur_clamped = diff[TIME_BITS-1:0];
      end
   end

   always_comb begin
      kind_in       = KIND_NONE;
      out_second_in = second_ff;
      event_time_in = time_ff;
      duration_in   = '0;
      priority if (!status_ff[7]) begin
         kind_in = KIND_BAD;
      end else if (is_off) begin
         if (!tracked_ff) begin
            kind_in = KIND_NONE;
         end else if (rd_open) begin
            kind_in       = KIND_NOTE;
            out_second_in = rd_vel;
            event_time_in = rd_time;
            duration_in   = dur_clamped;
         end else begin
            kind_in = KIND_UNMATCHED;
         end
      end else begin
         unique case (msg_type)
            MSG_NOTE_ON:   kind_in = KIND_NONE;
            MSG_KEYPRESS:  kind_in = KIND_KEYPRESS;
            MSG_CTRL:      kind_in = KIND_CTRL;
            MSG_PROG:      kind_in = KIND_PROG;
            MSG_CHANPRESS: kind_in = KIND_CHANPRESS;
            MSG_BEND:      kind_in = KIND_BEND;
            default:       kind_in = KIND_SYSTEM;
         endcase
      end
   end

   // single write port: clearing sweep or table update
   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = addr_ff;
      mem_wdata = {1'b0, rd_vel, rd_ff[TIME_BITS:0]};
      if (cmd.clear_step) begin
         mem_we    = 1'b1;
         mem_waddr = clr_cnt_ff;
         mem_wdata = '0;
      end else if (cmd.resolve && status_ff[7] && tracked_ff) begin
         if (is_off && rd_open) begin
            mem_we = 1'b1;
         end else if ((msg_type == MSG_NOTE_ON) && !is_off && !rd_open) begin
            mem_we    = 1'b1;
            mem_wdata = {1'b1, second_ff, time_ff};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.resolve;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.resolve) begin
         kind_ff       <= kind_in;
         chan_ff       <= status_ff[3:0];
         out_first_ff  <= first_ff;
         out_second_ff <= out_second_in;
         event_time_ff <= event_time_in;
         duration_ff   <= duration_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_kind          = kind_ff;
   assign rsp_chan          = chan_ff;
   assign rsp_out_first     = out_first_ff;
   assign rsp_out_second    = out_second_ff;
   assign rsp_event_time_us = event_time_ff;
   assign rsp_duration_us   = duration_ff;

endmodule

// ===== rtl/midi_note_pairing_recorder.sv =====
// ----------------------------------------------------------------------------
// midi_note_pairing_recorder
// Pairs MIDI note-on/note-off messages into timed notes and tags other
// channel messages by type.
// ----------------------------------------------------------------------------
// After reset, busy stays high while the open-note table is swept clear;
// the latency register can be written during that time. Each message then
// passes an accept step and a resolve step: the cycle that accepts it reads
// the table entry for its channel and note, the next cycle resolves it and
// updates the entry where needed through the table's single port, so busy is
// high for one cycle after every accepted beat. The result beat appears on the
// rsp_ ports with rsp_valid high for exactly one cycle, the cycle after
// resolution, and is not held: the receiver must take it then.
module midi_note_pairing_recorder #(
   parameter int CHANNEL_COUNT = mnpr_pkg::CHANNEL_COUNT_DEFAULT,
   parameter int TIME_BITS     = mnpr_pkg::TIME_BITS_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_we,
   input  logic [mnpr_pkg::LATENCY_BITS-1:0] csr_wdata,
   input  logic                              start,
   output logic                              busy,
   input  logic [7:0]                        req_status_byte,
   input  logic [mnpr_pkg::DATA_BITS-1:0]    req_first_data,
   input  logic [mnpr_pkg::DATA_BITS-1:0]    req_second_data,
   input  logic [TIME_BITS-1:0]              req_arrival_time_us,
   output logic                              rsp_valid,
   output logic [3:0]                        rsp_kind,
   output logic [3:0]                        rsp_chan,
   output logic [mnpr_pkg::DATA_BITS-1:0]    rsp_out_first,
   output logic [mnpr_pkg::DATA_BITS-1:0]    rsp_out_second,
   output logic signed [TIME_BITS:0]         rsp_event_time_us,
   output logic [TIME_BITS-1:0]              rsp_duration_us
);
   import mnpr_pkg::*;

   mnpr_cmd_type  cmd;
   mnpr_stat_type stat;

   mnpr_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .cmd   (cmd),
      .stat  (stat)
   );

   mnpr_datapath #(
      .CHANNEL_COUNT (CHANNEL_COUNT),
      .TIME_BITS     (TIME_BITS)
   ) u_datapath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .stat                (stat),
      .csr_we              (csr_we),
      .csr_wdata           (csr_wdata),
      .req_status_byte     (req_status_byte),
      .req_first_data      (req_first_data),
      .req_second_data     (req_second_data),
      .req_arrival_time_us (req_arrival_time_us),
      .rsp_valid           (rsp_valid),
      .rsp_kind            (rsp_kind),
      .rsp_chan            (rsp_chan),
      .rsp_out_first       (rsp_out_first),
      .rsp_out_second      (rsp_out_second),
      .rsp_event_time_us   (rsp_event_time_us),
      .rsp_duration_us     (rsp_duration_us)
   );

endmodule
